FILE: src/bqn_pkg.sv
// ----------------------------------------------------------------------------
// bqn_pkg
// Shared constants and types of the three-axis biquad notch filter.
// ----------------------------------------------------------------------------
package bqn_pkg;

    // One filter lane per gyro axis; the ports name the axes, so this is fixed.
    localparam int AXES      = 3;
    localparam int NUM_COEFS = 5;

    // Configuration port geometry: five 32-bit registers at byte address 4*i.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

    // Load enables of the three pipeline stages, shared by every lane.
    typedef struct packed {
        logic en_prod;   // item accepted: products and input history load
        logic en_sum;    // feedforward sum loads
        logic en_out;    // feedback stage fires into the output register
    } bqn_pipe_en_t;

endpackage

FILE: src/bqn_apb_regs.sv
// ----------------------------------------------------------------------------
// bqn_apb_regs
// APB register file holding the five shared filter coefficients.
// ----------------------------------------------------------------------------
module bqn_apb_regs
    import bqn_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [APB_ADDR_W-1:0]               paddr,
    input  logic [APB_DATA_W-1:0]               pwdata,
    output logic [APB_DATA_W-1:0]               prdata,
    output logic                                pready,
    output logic signed [COEF_FRAC_BITS+1:0]    coef_b0,
    output logic signed [COEF_FRAC_BITS+1:0]    coef_b1,
    output logic signed [COEF_FRAC_BITS+1:0]    coef_b2,
    output logic signed [COEF_FRAC_BITS+1:0]    coef_a1,
    output logic signed [COEF_FRAC_BITS+1:0]    coef_a2
);

    localparam int COEF_W = COEF_FRAC_BITS + 2;
    localparam logic [COEF_W-1:0] UNITY = {{(COEF_W-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;

    logic [COEF_W-1:0]    b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;
    logic [COEF_W-1:0]    wdata;
    logic [COEF_W-1:0]    rd_coef;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wdata  = pwdata[COEF_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg <= UNITY;
            b1_reg <= '0;
            b2_reg <= '0;
            a1_reg <= '0;
            a2_reg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_B0:  b0_reg <= wdata;
                REG_B1:  b1_reg <= wdata;
                REG_B2:  b2_reg <= wdata;
                REG_A1:  a1_reg <= wdata;
                REG_A2:  a2_reg <= wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_B0:  rd_coef = b0_reg;
            REG_B1:  rd_coef = b1_reg;
            REG_B2:  rd_coef = b2_reg;
            REG_A1:  rd_coef = a1_reg;
            REG_A2:  rd_coef = a2_reg;
            default: rd_coef = '0;
        endcase
    end

    // Reads return the coefficient sign-extended to the bus width.
    assign prdata = {{(APB_DATA_W-COEF_W){rd_coef[COEF_W-1]}}, rd_coef};

    assign coef_b0 = b0_reg;
    assign coef_b1 = b1_reg;
    assign coef_b2 = b2_reg;
    assign coef_a1 = a1_reg;
    assign coef_a2 = a2_reg;

endmodule

FILE: src/bqn_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// bqn_pipe_ctrl
// Valid tracking and load enables of the three-stage lane pipeline.
// ----------------------------------------------------------------------------
module bqn_pipe_ctrl
    import bqn_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output bqn_pipe_en_t  pipe_en
);

    logic prod_vld_reg, prod_vld_next;
    logic sum_vld_reg,  sum_vld_next;
    logic out_vld_reg,  out_vld_next;
    logic en_prod, en_sum, en_out;

    // Each stage moves on when the stage after it is empty or emptying.
    assign en_out  = sum_vld_reg  & (~out_vld_reg | m_ready);
    assign en_sum  = prod_vld_reg & (~sum_vld_reg | en_out);
    assign s_ready = ~prod_vld_reg | en_sum;
    assign en_prod = s_valid & s_ready;

    always_comb begin
        prod_vld_next = en_prod | (prod_vld_reg & ~en_sum);
        sum_vld_next  = en_sum  | (sum_vld_reg  & ~en_out);
        out_vld_next  = en_out  | (out_vld_reg  & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            prod_vld_reg <= prod_vld_next;
            sum_vld_reg  <= sum_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    assign m_valid         = out_vld_reg;
    assign pipe_en.en_prod = en_prod;
    assign pipe_en.en_sum  = en_sum;
    assign pipe_en.en_out  = en_out;

endmodule

FILE: src/bqn_lane.sv
// ----------------------------------------------------------------------------
// bqn_lane
// One axis of the filter: direct form I biquad with its own delay lines.
// ----------------------------------------------------------------------------
module bqn_lane
    import bqn_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bqn_pipe_en_t                        pipe_en,
    input  logic signed [SAMPLE_BITS-1:0]       x_in,
    input  logic signed [COEF_FRAC_BITS+1:0]    coef_b0,
    input  logic signed [COEF_FRAC_BITS+1:0]    coef_b1,
    input  logic signed [COEF_FRAC_BITS+1:0]    coef_b2,
    input  logic signed [COEF_FRAC_BITS+1:0]    coef_a1,
    input  logic signed [COEF_FRAC_BITS+1:0]    coef_a2,
    output logic signed [SAMPLE_BITS-1:0]       y_out,
    output logic                                sat_out
);

    localparam int COEF_W = COEF_FRAC_BITS + 2;
    localparam int PW     = SAMPLE_BITS + COEF_W;
    localparam int FF_W   = PW + 2;
    localparam int ACC_W  = PW + 3;
    localparam int RW     = ACC_W - COEF_FRAC_BITS;
    localparam int TOP_W  = RW - SAMPLE_BITS + 1;
    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] x1_reg, x2_reg;
    logic signed [SAMPLE_BITS-1:0] y1_reg, y2_reg;
    logic signed [PW-1:0]          p0_reg, p1_reg, p2_reg;
    logic signed [PW-1:0]          p0_next, p1_next, p2_next;
    logic signed [FF_W-1:0]        ff_reg, ff_next;
    logic signed [PW-1:0]          fb1, fb2;
    logic signed [ACC_W-1:0]       acc;
    logic signed [RW-1:0]          rnd;
    logic [TOP_W-1:0]              rnd_top;
    logic                          ovf;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    // Feedforward products of the accepted sample and its input history.
    assign p0_next = coef_b0 * x_in;
    assign p1_next = coef_b1 * x1_reg;
    assign p2_next = coef_b2 * x2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_reg <= '0;
            x2_reg <= '0;
        end else if (pipe_en.en_prod) begin
            x2_reg <= x1_reg;
            x1_reg <= x_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en.en_prod) begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    assign ff_next = FF_W'(p0_reg) + FF_W'(p1_reg) + FF_W'(p2_reg);

    always_ff @(posedge aclk) begin
        if (pipe_en.en_sum) begin
            ff_reg <= ff_next;
        end
    end

    // Feedback stage: the only part of the recursion, closed through the two output taps alone.
    assign fb1 = coef_a1 * y1_reg;
    assign fb2 = coef_a2 * y2_reg;
    assign acc = ACC_W'(ff_reg) - ACC_W'(fb1) - ACC_W'(fb2) + ROUND_HALF;
    assign rnd = acc[ACC_W-1:COEF_FRAC_BITS];

    // The rounded value fits when all bits above the sample's sign bit agree with it.
    assign rnd_top = rnd[RW-1:SAMPLE_BITS-1];
    assign ovf     = ~((&rnd_top) | ~(|rnd_top));
    assign y_sat   = ovf ? (rnd[RW-1] ? SAMPLE_MIN : SAMPLE_MAX) : rnd[SAMPLE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y1_reg <= '0;
            y2_reg <= '0;
        end else if (pipe_en.en_out) begin
            y2_reg <= y1_reg;
            y1_reg <= y_sat;
        end
    end

    assign y_out   = y_sat;
    assign sat_out = ovf;

endmodule

FILE: src/bqn_merge.sv
// ----------------------------------------------------------------------------
// bqn_merge
// Output register gathering the lane results and their clip flags.
// ----------------------------------------------------------------------------
module bqn_merge
    import bqn_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  bqn_pipe_en_t                        pipe_en,
    input  logic [AXES-1:0][SAMPLE_BITS-1:0]    lane_y,
    input  logic [AXES-1:0]                     lane_sat,
    output logic [AXES-1:0][SAMPLE_BITS-1:0]    y_out,
    output logic [AXES-1:0]                     sat_out
);

    logic [AXES-1:0][SAMPLE_BITS-1:0] y_reg;
    logic [AXES-1:0]                  sat_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en.en_out) begin
            y_reg   <= lane_y;
            sat_reg <= lane_sat;
        end
    end

    assign y_out   = y_reg;
    assign sat_out = sat_reg;

endmodule

FILE: src/three_axis_biquad_notch_core.sv
// ----------------------------------------------------------------------------
// three_axis_biquad_notch_core
// Three-axis direct form I biquad filter for gyro rate samples.
//
// Each input item carries one signed sample per axis (s_gyro_*_in) and is
// taken on s_valid and s_ready both high. Every axis has its own filter lane
// with two input and two output delay taps; all lanes share the five
// coefficients b0, b1, b2, a1, a2 (signed Q2.COEF_FRAC_BITS) written over the
// APB port at byte addresses 0x00 to 0x10. Each item gives exactly one result
// item: the rounded, saturated outputs and one clip flag per axis.
// The item passes the product, feedforward sum and output registers in turn
// before m_valid rises. A new item is taken every cycle while the receiver
// does not hold m_ready low; the rate is set by the feedback stage, which
// closes the recursion on the two output taps alone.
// When the receiver holds m_ready low the pipeline fills and s_ready drops
// once all three stages hold items; nothing is lost or repeated.
// Reset (aresetn low at a clock edge) empties the pipeline, zeroes all delay
// taps and loads pass-through coefficients (b0 = 1.0, the rest zero).
// Coefficients are to be written only while no item is in flight.
// ----------------------------------------------------------------------------
module three_axis_biquad_notch_core
    import bqn_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_gyro_x_in,
    input  logic signed [SAMPLE_BITS-1:0] s_gyro_y_in,
    input  logic signed [SAMPLE_BITS-1:0] s_gyro_z_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_gyro_x_out,
    output logic signed [SAMPLE_BITS-1:0] m_gyro_y_out,
    output logic signed [SAMPLE_BITS-1:0] m_gyro_z_out,
    output logic [AXES-1:0]               m_saturated
);

    localparam int COEF_W = COEF_FRAC_BITS + 2;

    logic signed [COEF_W-1:0]          coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
    bqn_pipe_en_t                      pipe_en;
    logic [AXES-1:0][SAMPLE_BITS-1:0]  lane_x;
    logic [AXES-1:0][SAMPLE_BITS-1:0]  lane_y;
    logic [AXES-1:0]                   lane_sat;
    logic [AXES-1:0][SAMPLE_BITS-1:0]  out_y;

    bqn_apb_regs #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef_b0 (coef_b0),
        .coef_b1 (coef_b1),
        .coef_b2 (coef_b2),
        .coef_a1 (coef_a1),
        .coef_a2 (coef_a2)
    );

    bqn_pipe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .pipe_en (pipe_en)
    );

    assign lane_x[0] = s_gyro_x_in;
    assign lane_x[1] = s_gyro_y_in;
    assign lane_x[2] = s_gyro_z_in;

    for (genvar k = 0; k < AXES; k++) begin : g_lane
        bqn_lane #(
            .SAMPLE_BITS    (SAMPLE_BITS),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .pipe_en (pipe_en),
            .x_in    (lane_x[k]),
            .coef_b0 (coef_b0),
            .coef_b1 (coef_b1),
            .coef_b2 (coef_b2),
            .coef_a1 (coef_a1),
            .coef_a2 (coef_a2),
            .y_out   (lane_y[k]),
            .sat_out (lane_sat[k])
        );
    end

    bqn_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .aclk     (aclk),
        .pipe_en  (pipe_en),
        .lane_y   (lane_y),
        .lane_sat (lane_sat),
        .y_out    (out_y),
        .sat_out  (m_saturated)
    );

    assign m_gyro_x_out = out_y[0];
    assign m_gyro_y_out = out_y[1];
    assign m_gyro_z_out = out_y[2];

endmodule

FILE: tb/sv/three_axis_biquad_notch_checker.sv
// ----------------------------------------------------------------------------
// three_axis_biquad_notch_checker
// Watches the coefficient port and both item channels of the biquad notch
// core. It keeps its own copy of the coefficients and delay taps, predicts
// the filtered rates and clip flags of every accepted sample, and compares
// each result item with the oldest prediction.
// ----------------------------------------------------------------------------
module three_axis_biquad_notch_checker
    import bqn_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_gyro_x_in,
    input  logic signed [SAMPLE_BITS-1:0] s_gyro_y_in,
    input  logic signed [SAMPLE_BITS-1:0] s_gyro_z_in,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic signed [SAMPLE_BITS-1:0] m_gyro_x_out,
    input  logic signed [SAMPLE_BITS-1:0] m_gyro_y_out,
    input  logic signed [SAMPLE_BITS-1:0] m_gyro_z_out,
    input  logic [AXES-1:0]               m_saturated,
    output int                            mismatches,
    output int                            results_seen,
    output int                            clipped_axes,
    output int                            leftover
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     COEF_W     = COEF_FRAC_BITS + 2;
    localparam int     UNITY_GAIN = 1 << COEF_FRAC_BITS;
    localparam longint RATE_MAX   = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint RATE_MIN   = -(longint'(1) << (SAMPLE_BITS - 1));
    localparam int     REPORT_MAX = 10;

    typedef struct packed {
        logic [AXES-1:0][SAMPLE_BITS-1:0] rate;
        logic [AXES-1:0]                  clip;
    } filtered_t;

    logic signed [COEF_W-1:0]      coef [NUM_COEFS];
    logic signed [SAMPLE_BITS-1:0] x_d1 [AXES];
    logic signed [SAMPLE_BITS-1:0] x_d2 [AXES];
    logic signed [SAMPLE_BITS-1:0] y_d1 [AXES];
    logic signed [SAMPLE_BITS-1:0] y_d2 [AXES];
    filtered_t                     expected_rates [$];
    int                            fails;
    int                            n_results;
    int                            n_clipped;

    // Runs one sample through every axis lane and shifts the delay taps.
    function automatic filtered_t filter_sample(
        input logic [AXES-1:0][SAMPLE_BITS-1:0] sample
    );
        filtered_t                     res;
        longint                        acc;
        longint                        y;
        logic signed [SAMPLE_BITS-1:0] xs;
        res = '0;
        for (int k = 0; k < AXES; k++) begin
            xs  = sample[k];
            acc = longint'(coef[REG_B0]) * longint'(xs)
                + longint'(coef[REG_B1]) * longint'(x_d1[k])
                + longint'(coef[REG_B2]) * longint'(x_d2[k])
                - longint'(coef[REG_A1]) * longint'(y_d1[k])
                - longint'(coef[REG_A2]) * longint'(y_d2[k]);
            // Half a unit in, then an arithmetic shift: ties go upwards.
            y = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
            if (y > RATE_MAX) begin
                y = RATE_MAX;
                res.clip[k] = 1'b1;
            end else if (y < RATE_MIN) begin
                y = RATE_MIN;
                res.clip[k] = 1'b1;
            end
            res.rate[k] = y[SAMPLE_BITS-1:0];
            x_d2[k] = x_d1[k];
            x_d1[k] = xs;
            y_d2[k] = y_d1[k];
            y_d1[k] = y[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    initial begin
        fails     = 0;
        n_results = 0;
        n_clipped = 0;
    end

    assign mismatches   = fails;
    assign clipped_axes = n_clipped;

    always @(posedge aclk) begin
        filtered_t                   got;
        filtered_t                   want;
        logic [APB_ADDR_W-1:2]       idx;
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEFS; i++) coef[i] = '0;
            coef[REG_B0] = COEF_W'(UNITY_GAIN);
            for (int k = 0; k < AXES; k++) begin
                x_d1[k] = '0;
                x_d2[k] = '0;
                y_d1[k] = '0;
                y_d2[k] = '0;
            end
            expected_rates.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                idx = paddr[APB_ADDR_W-1:2];
                // Writes beyond the last coefficient are dropped.
                if (idx < NUM_COEFS) coef[idx] = pwdata[COEF_W-1:0];
            end
            // The result side is handled first so that an item accepted at
            // the same edge can never stand in for a missing prediction.
            if (m_valid && m_ready) begin
                got.rate = {m_gyro_z_out, m_gyro_y_out, m_gyro_x_out};
                got.clip = m_saturated;
                if (expected_rates.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("[%0t] unexpected result item: x=%0d y=%0d z=%0d clip=%b",
                                 $realtime, m_gyro_x_out, m_gyro_y_out, m_gyro_z_out,
                                 m_saturated);
                end else begin
                    want = expected_rates.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= REPORT_MAX)
                            $display({"[%0t] result %0d mismatch: expected x=%0d y=%0d z=%0d ",
                                      "clip=%b, got x=%0d y=%0d z=%0d clip=%b"},
                                     $realtime, n_results,
                                     $signed(want.rate[0]), $signed(want.rate[1]),
                                     $signed(want.rate[2]), want.clip,
                                     m_gyro_x_out, m_gyro_y_out, m_gyro_z_out,
                                     m_saturated);
                    end
                end
                n_results++;
            end
            if (s_valid && s_ready) begin
                want = filter_sample({s_gyro_z_in, s_gyro_y_in, s_gyro_x_in});
                n_clipped += $countones(want.clip);
                expected_rates.push_back(want);
            end
        end
        results_seen <= n_results;
        leftover     <= expected_rates.size();
    end

endmodule

FILE: tb/sv/tb_three_axis_biquad_notch_core.sv
// ----------------------------------------------------------------------------
// tb_three_axis_biquad_notch_core
// Stimulus and verdict for the three-axis biquad notch core. A short directed
// part covers the sample extremes, rounding ties, clipping and runaway
// feedback at the coefficient extremes and writes past the last register;
// random phases then use notch-like, small and arbitrary coefficient sets
// with random idling on both channels, one stretch without idling and one
// long hold-off of the receiver. Checking is done by the checker module.
// ----------------------------------------------------------------------------
module tb_three_axis_biquad_notch_core;
    import bqn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS     = 16;
    localparam int COEF_FRAC_BITS  = 16;
    localparam int COEF_W          = COEF_FRAC_BITS + 2;
    localparam int COEF_MAX        = 131071;
    localparam int COEF_MIN        = -131072;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int CALM_PHASE      = 3;
    localparam int HOLD_PHASE      = 5;
    localparam int HOLD_CYCLES     = 64;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 8;

    logic                          aclk;
    logic                          aresetn;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [APB_ADDR_W-1:0]         paddr;
    logic [APB_DATA_W-1:0]         pwdata;
    logic [APB_DATA_W-1:0]         prdata;
    logic                          pready;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_gyro_x_in;
    logic signed [SAMPLE_BITS-1:0] s_gyro_y_in;
    logic signed [SAMPLE_BITS-1:0] s_gyro_z_in;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [SAMPLE_BITS-1:0] m_gyro_x_out;
    logic signed [SAMPLE_BITS-1:0] m_gyro_y_out;
    logic signed [SAMPLE_BITS-1:0] m_gyro_z_out;
    logic [AXES-1:0]               m_saturated;

    int mismatches;
    int results_seen;
    int clipped_axes;
    int leftover;

    int items_sent;
    int settings_used;
    int hold_asked;
    int hold_served;
    bit calm;

    logic signed [SAMPLE_BITS-1:0] walk_x;
    logic signed [SAMPLE_BITS-1:0] walk_y;
    logic signed [SAMPLE_BITS-1:0] walk_z;

    three_axis_biquad_notch_core #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_gyro_x_in  (s_gyro_x_in),
        .s_gyro_y_in  (s_gyro_y_in),
        .s_gyro_z_in  (s_gyro_z_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gyro_x_out (m_gyro_x_out),
        .m_gyro_y_out (m_gyro_y_out),
        .m_gyro_z_out (m_gyro_z_out),
        .m_saturated  (m_saturated)
    );

    three_axis_biquad_notch_checker #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_gyro_x_in  (s_gyro_x_in),
        .s_gyro_y_in  (s_gyro_y_in),
        .s_gyro_z_in  (s_gyro_z_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_gyro_x_out (m_gyro_x_out),
        .m_gyro_y_out (m_gyro_y_out),
        .m_gyro_z_out (m_gyro_z_out),
        .m_saturated  (m_saturated),
        .mismatches   (mismatches),
        .results_seen (results_seen),
        .clipped_axes (clipped_axes),
        .leftover     (leftover)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int rand_span(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] extreme_rate();
        case ($urandom_range(0, 3))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'shffff;
        endcase
    endfunction

    // A slowly drifting rate, clamped to the sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] drift(
        input logic signed [SAMPLE_BITS-1:0] prev
    );
        int v;
        v = int'(prev) + rand_span(-2048, 2048);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Waits until every sample sent has come back.
    task automatic settle();
        while (results_seen != items_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_coef(input logic [REG_IDX_W-1:0] idx, input int value);
        logic [APB_DATA_W-1:0] word;
        word = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {word[APB_DATA_W-1:COEF_W], value[COEF_W-1:0]};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_coefs(input int b0, input int b1, input int b2,
                             input int a1, input int a2);
        settle();
        write_coef(REG_B0, b0);
        write_coef(REG_B1, b1);
        write_coef(REG_B2, b2);
        write_coef(REG_A1, a1);
        write_coef(REG_A2, a2);
        settings_used++;
    endtask

    task automatic send_item(input logic signed [SAMPLE_BITS-1:0] x,
                             input logic signed [SAMPLE_BITS-1:0] y,
                             input logic signed [SAMPLE_BITS-1:0] z);
        s_valid     <= 1'b1;
        s_gyro_x_in <= x;
        s_gyro_y_in <= y;
        s_gyro_z_in <= z;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (!calm && $urandom_range(0, 99) < 15) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
    endtask

    task automatic send_random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            walk_x = drift(walk_x);
            walk_y = drift(walk_y);
            walk_z = drift(walk_z);
            send_item(walk_x, walk_y, walk_z);
        end else if (r < 90) begin
            send_item(SAMPLE_BITS'($urandom()), SAMPLE_BITS'($urandom()),
                      SAMPLE_BITS'($urandom()));
        end else begin
            send_item(extreme_rate(), extreme_rate(), extreme_rate());
        end
    endtask

    // Receiver: random stalls, none while calm, and a long hold-off on request.
    initial begin
        hold_served = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_served != hold_asked) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
                hold_served++;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // Ends the run when nothing has moved on any port for too long.
    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel)
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL three_axis_biquad_notch_core");
        $finish;
    end

    initial begin
        int b0;
        items_sent    = 0;
        settings_used = 1;
        hold_asked    = 0;
        calm          = 1'b0;
        walk_x        = '0;
        walk_y        = '0;
        walk_z        = '0;
        aresetn     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        s_valid     <= 1'b0;
        s_gyro_x_in <= '0;
        s_gyro_y_in <= '0;
        s_gyro_z_in <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Pass-through coefficients straight out of reset.
        send_item(16'sh7fff, 16'sh8000, 16'sh0000);
        send_item(16'shffff, 16'sh0001, 16'sh5555);
        send_item(16'sh3039, 16'shcfc7, 16'sh00ff);
        s_valid <= 1'b0;

        // Gain of one half: odd samples land exactly on a rounding tie.
        set_coefs(32768, 0, 0, 0, 0);
        send_item(16'sh0001, 16'shffff, 16'sh0003);
        send_item(16'shfffd, 16'sh7fff, 16'sh8000);
        s_valid <= 1'b0;

        // Largest weights with positive feedback: clips and stays pinned.
        set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        repeat (4) send_item(16'sh7fff, 16'sh8000, 16'sh0001);
        repeat (2) send_item(16'sh0000, 16'sh0000, 16'sh0000);
        s_valid <= 1'b0;

        // Most negative weights everywhere.
        set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        repeat (3) send_item(16'sh8000, 16'sh7fff, 16'sh0000);
        repeat (2) send_item(16'sh0000, 16'sh0000, 16'sh0000);
        s_valid <= 1'b0;

        // Writes past the last coefficient must leave the filter unchanged.
        settle();
        for (int k = NUM_COEFS; k < (1 << REG_IDX_W); k++)
            write_coef(REG_IDX_W'(k), int'($urandom()));
        repeat (2) send_item(16'sh0064, 16'shff9c, 16'sh0007);
        s_valid <= 1'b0;

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 3)
                0: begin
                    // Notch-like section near the unit circle.
                    b0 = 58982 + rand_span(-4096, 4096);
                    set_coefs(b0, -111411 + rand_span(-8192, 8192), b0,
                              -111411 + rand_span(-8192, 8192),
                              52429 + rand_span(-8192, 8192));
                end
                1: set_coefs(rand_span(COEF_MIN, COEF_MAX), rand_span(COEF_MIN, COEF_MAX),
                             rand_span(COEF_MIN, COEF_MAX), rand_span(COEF_MIN, COEF_MAX),
                             rand_span(COEF_MIN, COEF_MAX));
                default: set_coefs(rand_span(-32768, 32767), rand_span(-32768, 32767),
                                   rand_span(-32768, 32767), rand_span(-32768, 32767),
                                   rand_span(-32768, 32767));
            endcase
            calm = (ph == CALM_PHASE);
            if (ph == HOLD_PHASE) hold_asked++;
            repeat (ITEMS_PER_PHASE) send_random_item();
            s_valid <= 1'b0;
        end
        calm = 1'b0;

        while (results_seen != items_sent) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d samples over %0d coefficient settings; %0d axis outputs clipped.",
                 items_sent, settings_used, clipped_axes);
        $display("Receiver held off %0d times for %0d cycles; %0d mismatches, %0d left over.",
                 hold_asked, HOLD_CYCLES, mismatches, leftover);
        if (mismatches == 0 && leftover == 0) begin
            $display("PASS three_axis_biquad_notch_core");
        end else begin
            $display("FAIL three_axis_biquad_notch_core");
        end
        $finish;
    end

endmodule

FILE: three_axis_biquad_notch_core.f
src/bqn_pkg.sv
src/bqn_apb_regs.sv
src/bqn_pipe_ctrl.sv
src/bqn_lane.sv
src/bqn_merge.sv
src/three_axis_biquad_notch_core.sv
tb/sv/three_axis_biquad_notch_checker.sv
tb/sv/tb_three_axis_biquad_notch_core.sv
